// File: hdl/tmq_pkg.sv
// Shared widths, status codes, register indexes and entry type for the message queue.
package tmq_pkg;

  localparam int TYPE_W     = 32;
  localparam int WORD_W     = 64;
  localparam int BLEN_W     = 16;
  localparam int LEN_W      = 7;
  localparam int ST_W       = 3;
  localparam int CAP_W      = 5;
  localparam int OVH_W      = 8;
  localparam int COST_W     = 9;
  localparam int BUD_W      = 14;
  localparam int NW_W       = 5;
  localparam int SLOTF_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd1;
  localparam logic [ST_W-1:0] ST_LONG     = 3'd2;
  localparam logic [ST_W-1:0] ST_EMPTY    = 3'd3;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;
  localparam logic [ST_W-1:0] ST_SMALL    = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERHEAD = 2'd2;

  typedef struct packed {
    logic signed [TYPE_W-1:0] typ;
    logic [LEN_W-1:0]         len;
    logic [SLOTF_W-1:0]       slot;
    logic [COST_W-1:0]        cost;
  } entry_t;

endpackage

// File: hdl/tmq_ifs.sv
// Request and response channel interfaces of the message queue.
interface tmq_req_if import tmq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     func;
  logic signed [TYPE_W-1:0] mtype;
  logic [WORD_W-1:0]        payload_word;
  logic [BLEN_W-1:0]        byte_len;
  logic                     last_word;
  modport source(output valid, func, mtype, payload_word, byte_len, last_word,
                 input ready);
  modport sink(input valid, func, mtype, payload_word, byte_len, last_word,
               output ready);
endinterface

interface tmq_rsp_if import tmq_pkg::*; #(parameter int CNT_W = 5) ();
  logic                     valid;
  logic                     ready;
  logic [ST_W-1:0]          status;
  logic signed [TYPE_W-1:0] out_type;
  logic [WORD_W-1:0]        out_word;
  logic [LEN_W-1:0]         out_len;
  logic                     out_last;
  logic [CNT_W-1:0]         stored_count;
  modport source(output valid, status, out_type, out_word, out_len, out_last,
                 stored_count, input ready);
  modport sink(input valid, status, out_type, out_word, out_len, out_last,
               stored_count, output ready);
endinterface

// File: hdl/typed_message_queue_core.sv
// Top level: typed message queue with ordered entry memory and payload memory.
//
//  channel | dir | handshake          | content
//  req     | in  | valid/ready        | func, mtype, payload_word, byte_len, last_word
//  rsp     | out | valid/ready        | status, out_type, out_word, out_len, out_last, count
//  cfg     | in  | cfg_we, no stall   | cfg_index, cfg_data
//
// A non-final send word is written at once; a commit zero-fills unused slot words, masks a
// partial last word and reports. A receive scans the entries in order, then gives an error
// result, or sends each result word and shifts later entries down in the order list.
// Reset is synchronous; it frees all slots and clears counts, memories are not cleared.
// The next item is taken only once the current one is finished; results stall on rsp.ready.
module typed_message_queue_core import tmq_pkg::*; #(
  parameter int MAX_MSGS  = 16,
  parameter int MAX_WORDS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  tmq_req_if.sink               req,
  tmq_rsp_if.source             rsp
);
  localparam int SLOT_W = $clog2(MAX_MSGS);
  localparam int CNT_W  = $clog2(MAX_MSGS + 1);
  localparam int WI_W   = $clog2(MAX_WORDS + 1);
  localparam int PDEPTH = MAX_MSGS * MAX_WORDS;
  localparam int PA_W   = $clog2(PDEPTH);
  localparam int MAXB   = MAX_WORDS * 8;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CZERO  = 4'd1;
  localparam logic [3:0] S_CMRD   = 4'd2;
  localparam logic [3:0] S_CMWR   = 4'd3;
  localparam logic [3:0] S_RESULT = 4'd4;
  localparam logic [3:0] S_SCAN   = 4'd5;
  localparam logic [3:0] S_WRD    = 4'd6;
  localparam logic [3:0] S_WPUSH  = 4'd7;
  localparam logic [3:0] S_SHRD   = 4'd8;
  localparam logic [3:0] S_SHWR   = 4'd9;

  function automatic logic type_match(input logic signed [TYPE_W-1:0] s,
                                      input logic signed [TYPE_W-1:0] t);
    logic signed [TYPE_W:0] s_x;
    logic signed [TYPE_W:0] t_x;
    s_x = {s[TYPE_W-1], s};
    t_x = {t[TYPE_W-1], t};
    return (s == t) || (s[TYPE_W-1] && (t_x <= -s_x));
  endfunction

  function automatic logic [PA_W-1:0] paddr(input logic [SLOT_W-1:0] slot,
                                            input logic [WI_W-1:0] k);
    return PA_W'(slot) * PA_W'(MAX_WORDS) + PA_W'(k);
  endfunction

  function automatic logic [WI_W-1:0] words_of(input logic [LEN_W-1:0] len);
    logic [NW_W-1:0] nw;
    nw = NW_W'(({1'b0, len} + 8'd7) >> 3);
    return (32'(nw) > MAX_WORDS) ? WI_W'(MAX_WORDS) : WI_W'(nw);
  endfunction

  // configuration
  logic [CAP_W-1:0] cap_r;
  logic [LEN_W-1:0] maxlen_r;
  logic [OVH_W-1:0] ovh_r;

  // control state
  logic [3:0]               state, state_next;
  logic [CNT_W-1:0]         held, held_next;
  logic [BUD_W-1:0]         used, used_next;
  logic [WI_W-1:0]          widx, widx_next;
  logic [ST_W-1:0]          res_st, res_st_next;
  logic signed [TYPE_W-1:0] sel, sel_next;
  logic [BLEN_W-1:0]        blen_r, blen_r_next;
  logic [SLOT_W-1:0]        cslot, cslot_next;
  logic [LEN_W-1:0]         clen, clen_next;
  logic                     mask_need, mask_need_next;
  logic [WI_W-1:0]          nw_r, nw_r_next;
  logic [WI_W-1:0]          k, k_next;
  entry_t                   ent, ent_next;
  logic [CNT_W-1:0]         pos, pos_next;
  logic [CNT_W-1:0]         rd_i, rd_i_next;
  logic [CNT_W-1:0]         chk_i, chk_i_next;
  logic                     chk_v, chk_v_next;
  logic [CNT_W-1:0]         sh_i, sh_i_next;

  // memories
  logic [WORD_W-1:0] pmem [PDEPTH];
  logic              p_we;
  logic [PA_W-1:0]   p_waddr;
  logic [WORD_W-1:0] p_wdata;
  logic [PA_W-1:0]   p_raddr;
  logic [WORD_W-1:0] p_rdata;

  entry_t            emem [MAX_MSGS];
  logic              e_we;
  logic [SLOT_W-1:0] e_waddr;
  entry_t            e_wdata;
  logic [SLOT_W-1:0] e_raddr;
  entry_t            e_rdata;

  // free map
  logic              alloc_en, rel_en, any_free;
  logic [SLOT_W-1:0] low_slot, rel_slot;

  // output register
  logic                     o_valid;
  logic [ST_W-1:0]          o_status;
  logic signed [TYPE_W-1:0] o_type;
  logic [WORD_W-1:0]        o_word;
  logic [LEN_W-1:0]         o_len;
  logic                     o_last;
  logic [CNT_W-1:0]         o_count;
  logic                     push;
  logic [ST_W-1:0]          push_st;
  logic signed [TYPE_W-1:0] push_type;
  logic [WORD_W-1:0]        push_word;
  logic [LEN_W-1:0]         push_len;
  logic                     push_last;
  logic                     can_push;

  // commit checks
  logic [COST_W-1:0] cost;
  logic [COST_W-1:0] per_msg;
  logic [BUD_W-1:0]  budget;
  logic              too_long, full;
  logic [WI_W-1:0]   idx_after;
  logic [WI_W-1:0]   nw_in;
  logic              accept;
  logic              found;

  tmq_free_map #(.MAX_MSGS(MAX_MSGS)) u_free (
    .clk       (clk),
    .rst       (rst),
    .alloc_en  (alloc_en),
    .alloc_slot(low_slot),
    .rel_en    (rel_en),
    .rel_slot  (rel_slot),
    .any_free  (any_free),
    .low_slot  (low_slot)
  );

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign can_push  = !o_valid || rsp.ready;

  assign per_msg   = COST_W'(ovh_r) + COST_W'(maxlen_r);
  assign budget    = BUD_W'(per_msg) * BUD_W'(cap_r);
  assign cost      = COST_W'(ovh_r) + COST_W'(req.byte_len[LEN_W-1:0]);
  assign too_long  = (req.byte_len > BLEN_W'(maxlen_r)) || (req.byte_len > BLEN_W'(MAXB));
  assign full      = !any_free || (32'(held) >= MAX_MSGS) ||
                     (({1'b0, used} + (BUD_W + 1)'(cost)) > {1'b0, budget});
  assign idx_after = (32'(widx) < MAX_WORDS) ? widx + 1'b1 : widx;
  assign nw_in     = words_of(req.byte_len[LEN_W-1:0]);
  assign found     = chk_v && ((sel == '0) || type_match(sel, e_rdata.typ));
  assign rel_slot  = e_rdata.slot[SLOT_W-1:0];

  always_comb begin
    state_next     = state;
    held_next      = held;
    used_next      = used;
    widx_next      = widx;
    res_st_next    = res_st;
    sel_next       = sel;
    blen_r_next    = blen_r;
    cslot_next     = cslot;
    clen_next      = clen;
    mask_need_next = mask_need;
    nw_r_next      = nw_r;
    k_next         = k;
    ent_next       = ent;
    pos_next       = pos;
    rd_i_next      = rd_i;
    chk_i_next     = chk_i;
    chk_v_next     = 1'b0;
    sh_i_next      = sh_i;
    p_we           = 1'b0;
    p_waddr        = paddr(cslot, k);
    p_wdata        = '0;
    p_raddr        = paddr(ent.slot[SLOT_W-1:0], k);
    e_we           = 1'b0;
    e_waddr        = sh_i[SLOT_W-1:0];
    e_wdata        = e_rdata;
    e_raddr        = SLOT_W'(sh_i + 1'b1);
    alloc_en       = 1'b0;
    rel_en         = 1'b0;
    push           = 1'b0;
    push_st        = res_st;
    push_type      = '0;
    push_word      = '0;
    push_len       = '0;
    push_last      = 1'b1;

    case (state)
      S_IDLE: begin
        if (accept) begin
          if (!req.func) begin
            if (32'(widx) < MAX_WORDS) begin
              p_we      = any_free;
              p_waddr   = paddr(low_slot, widx);
              p_wdata   = req.payload_word;
              widx_next = widx + 1'b1;
            end
            if (req.last_word) begin
              widx_next = '0;
              if (too_long) begin
                res_st_next = ST_LONG;
                state_next  = S_RESULT;
              end else if (full) begin
                res_st_next = ST_FULL;
                state_next  = S_RESULT;
              end else begin
                alloc_en       = 1'b1;
                e_we           = 1'b1;
                e_waddr        = held[SLOT_W-1:0];
                e_wdata.typ    = req.mtype;
                e_wdata.len    = req.byte_len[LEN_W-1:0];
                e_wdata.slot   = SLOTF_W'(low_slot);
                e_wdata.cost   = cost;
                held_next      = held + 1'b1;
                used_next      = used + BUD_W'(cost);
                cslot_next     = low_slot;
                clen_next      = req.byte_len[LEN_W-1:0];
                nw_r_next      = nw_in;
                k_next         = idx_after;
                mask_need_next = (req.byte_len[2:0] != 3'd0) && (nw_in <= idx_after);
                res_st_next    = ST_OK;
                state_next     = S_CZERO;
              end
            end
          end else begin
            sel_next    = req.mtype;
            blen_r_next = req.byte_len;
            if (held == '0) begin
              res_st_next = ST_EMPTY;
              state_next  = S_RESULT;
            end else begin
              rd_i_next  = '0;
              state_next = S_SCAN;
            end
          end
        end
      end
      S_CZERO: begin
        if (k < nw_r) begin
          p_we   = 1'b1;
          k_next = k + 1'b1;
        end else begin
          state_next = mask_need ? S_CMRD : S_RESULT;
        end
      end
      S_CMRD: begin
        p_raddr    = paddr(cslot, nw_r - 1'b1);
        state_next = S_CMWR;
      end
      S_CMWR: begin
        p_we       = 1'b1;
        p_waddr    = paddr(cslot, nw_r - 1'b1);
        p_wdata    = p_rdata & ((WORD_W'(1) << {clen[2:0], 3'b000}) - 1'b1);
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (can_push) begin
          push       = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        e_raddr    = rd_i[SLOT_W-1:0];
        chk_v_next = (rd_i < held);
        chk_i_next = rd_i;
        if (rd_i < held) rd_i_next = rd_i + 1'b1;
        if (found) begin
          chk_v_next = 1'b0;
          if (blen_r < BLEN_W'(e_rdata.len)) begin
            res_st_next = ST_SMALL;
            state_next  = S_RESULT;
          end else begin
            rel_en     = 1'b1;
            held_next  = held - 1'b1;
            used_next  = (used >= BUD_W'(e_rdata.cost)) ? used - BUD_W'(e_rdata.cost) : '0;
            ent_next   = e_rdata;
            pos_next   = chk_i;
            nw_r_next  = words_of(e_rdata.len);
            k_next     = '0;
            state_next = S_WRD;
          end
        end else if (chk_v && (chk_i + 1'b1 == held)) begin
          chk_v_next  = 1'b0;
          res_st_next = ST_NOTFOUND;
          state_next  = S_RESULT;
        end
      end
      S_WRD: begin
        state_next = S_WPUSH;
      end
      S_WPUSH: begin
        push_st   = ST_OK;
        push_type = ent.typ;
        push_word = (nw_r == '0) ? '0 : p_rdata;
        push_len  = ent.len;
        push_last = (({1'b0, k} + 1'b1) >= {1'b0, nw_r});
        if (can_push) begin
          push = 1'b1;
          if (push_last) begin
            sh_i_next  = pos;
            state_next = S_SHRD;
          end else begin
            k_next     = k + 1'b1;
            state_next = S_WRD;
          end
        end
      end
      S_SHRD: begin
        state_next = (sh_i < held) ? S_SHWR : S_IDLE;
      end
      S_SHWR: begin
        e_we       = 1'b1;
        sh_i_next  = sh_i + 1'b1;
        state_next = S_SHRD;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (p_we) pmem[p_waddr] <= p_wdata;
    p_rdata <= pmem[p_raddr];
  end

  always_ff @(posedge clk) begin
    if (e_we) emem[e_waddr] <= e_wdata;
    e_rdata <= emem[e_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      held     <= '0;
      used     <= '0;
      widx     <= '0;
      chk_v    <= 1'b0;
      o_valid  <= 1'b0;
      cap_r    <= CAP_W'(16);
      maxlen_r <= LEN_W'(64);
      ovh_r    <= OVH_W'(16);
    end else begin
      state <= state_next;
      held  <= held_next;
      used  <= used_next;
      widx  <= widx_next;
      chk_v <= chk_v_next;
      if (push) o_valid <= 1'b1;
      else if (rsp.ready) o_valid <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          CFG_CAPACITY: cap_r    <= cfg_data[CAP_W-1:0];
          CFG_MAX_LEN:  maxlen_r <= cfg_data[LEN_W-1:0];
          CFG_OVERHEAD: ovh_r    <= cfg_data[OVH_W-1:0];
          default:      ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    res_st    <= res_st_next;
    sel       <= sel_next;
    blen_r    <= blen_r_next;
    cslot     <= cslot_next;
    clen      <= clen_next;
    mask_need <= mask_need_next;
    nw_r      <= nw_r_next;
    k         <= k_next;
    ent       <= ent_next;
    pos       <= pos_next;
    rd_i      <= rd_i_next;
    chk_i     <= chk_i_next;
    sh_i      <= sh_i_next;
    if (push) begin
      o_status <= push_st;
      o_type   <= push_type;
      o_word   <= push_word;
      o_len    <= push_len;
      o_last   <= push_last;
      o_count  <= held;
    end
  end

  assign rsp.valid        = o_valid;
  assign rsp.status       = o_status;
  assign rsp.out_type     = o_type;
  assign rsp.out_word     = o_word;
  assign rsp.out_len      = o_len;
  assign rsp.out_last     = o_last;
  assign rsp.stored_count = o_count;

`ifndef SYNTHESIS
  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    32'(held) <= MAX_MSGS) else $error("held count above slot count");
  a_bytes_empty: assert property (@(posedge clk) disable iff (rst)
    (held == '0) |-> (used == '0)) else $error("bytes charged with no message held");
  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && chk_v) |-> (chk_i < held)) else $error("scan past held entries");
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> (!o_valid || rsp.ready)) else $error("result overwritten before taken");
`endif

endmodule

// File: hdl/tmq_free_map.sv
// Free slot bitmap with lowest free slot encoder.
module tmq_free_map #(
  parameter int MAX_MSGS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        alloc_en,
  input  logic [$clog2(MAX_MSGS)-1:0] alloc_slot,
  input  logic                        rel_en,
  input  logic [$clog2(MAX_MSGS)-1:0] rel_slot,
  output logic                        any_free,
  output logic [$clog2(MAX_MSGS)-1:0] low_slot
);
  localparam int SLOT_W = $clog2(MAX_MSGS);

  logic [MAX_MSGS-1:0] free;

  always_ff @(posedge clk) begin
    if (rst) begin
      free <= '1;
    end else begin
      if (alloc_en) free[alloc_slot] <= 1'b0;
      if (rel_en) free[rel_slot] <= 1'b1;
    end
  end

  always_comb begin
    any_free = 1'b0;
    low_slot = '0;
    for (int i = MAX_MSGS - 1; i >= 0; i--) begin
      if (free[i]) begin
        any_free = 1'b1;
        low_slot = SLOT_W'(i);
      end
    end
  end

endmodule
